// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the translation and cache block.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/tpca_pkg.sv =====
// Package of the translation and cache block: sizes, constants and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none
package tpca_pkg;

  localparam int VA_W        = 10;
  localparam int STAMP_W     = 31;
  localparam int PAGE_W      = 7;
  localparam int OFF_W       = 3;
  localparam int FRAME_W     = 3;
  localparam int PA_W        = 6;
  localparam int TAG_W       = 4;
  localparam int VPAGES      = 128;
  localparam int TLB_ENTRIES = 32;
  localparam int TLB_IDX_W   = 5;
  localparam int FRAMES      = 8;
  localparam int WAYS        = 4;
  localparam int SCAN_W      = 5;

  localparam logic [STAMP_W-1:0] STAMP_CEIL = 31'h7FFF_FFFF;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic pt_load;
    logic scan_start;
    logic scan_step;
    logic scan_tlb;
    logic evict;
    logic map;
    logic tlb_fill;
    logic cache;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic tlb_hit;
    logic table_valid;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== design/tpca_ctrl.sv =====
// Sequencer of the translation and cache block: walks one transfer through
// lookup, fault handling, TLB refill and cache access. Uses tpca_pkg.
`default_nettype none
module tpca_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  tpca_pkg::status_t    status_i,
  output tpca_pkg::cmd_t       cmd_o
);
  import tpca_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_PT, S_FSCAN, S_EVICT, S_MAP, S_TSCAN, S_TFILL, S_CACHE, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd_o.lookup     = 1'b1;
        cmd_o.scan_start = 1'b1;
        if (status_i.tlb_hit) state_d = S_CACHE;
        else if (status_i.table_valid) state_d = S_PT;
        else state_d = S_FSCAN;
      end
      S_PT: begin
        cmd_o.pt_load    = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_TSCAN;
      end
      S_FSCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) state_d = S_EVICT;
      end
      S_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = S_MAP;
      end
      S_MAP: begin
        cmd_o.map        = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_TSCAN;
      end
      S_TSCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_tlb  = 1'b1;
        if (status_i.scan_last) state_d = S_TFILL;
      end
      S_TFILL: begin
        cmd_o.tlb_fill = 1'b1;
        state_d        = S_CACHE;
      end
      S_CACHE: begin
        cmd_o.cache = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        cmd_o.load_out = status_i.out_free;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/tpca_datapath.sv =====
// Datapath of the translation and cache block: TLB, page table memory, frame
// table, cache lines, replacement scan and output register. Uses tpca_pkg.
`default_nettype none
module tpca_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  tpca_pkg::cmd_t                     cmd_i,
  output tpca_pkg::status_t                  status_o,
  input  wire logic [tpca_pkg::VA_W-1:0]     virtual_address_i,
  input  wire logic [tpca_pkg::STAMP_W-1:0]  cycle_stamp_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               tlb_hit_o,
  output logic                               page_table_hit_o,
  output logic                               page_fault_o,
  output logic                               cache_hit_o,
  output logic [tpca_pkg::FRAME_W-1:0]       frame_number_o,
  output logic [tpca_pkg::PA_W-1:0]          physical_address_o
);
  import tpca_pkg::*;

  logic [PAGE_W-1:0]  page_q;
  logic [OFF_W-1:0]   offset_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [FRAME_W-1:0] frame_q;
  logic               free_q;

  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  logic [PAGE_W-1:0]      tlb_page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame_q [TLB_ENTRIES];
  logic [STAMP_W-1:0]     tlb_stamp_q [TLB_ENTRIES];

  logic [VPAGES-1:0]  table_valid_q;
  logic [FRAME_W-1:0] table_mem [VPAGES];
  logic [FRAME_W-1:0] table_rdata_q;

  logic [FRAMES-1:0]  frame_valid_q;
  logic [STAMP_W-1:0] frame_stamp_q [FRAMES];
  logic [PAGE_W-1:0]  frame_owner_q [FRAMES];

  logic [WAYS-1:0]    line_valid_q;
  logic [WAYS-1:0]    line_recent_q;
  logic [TAG_W-1:0]   line_tag_q [WAYS];

  logic res_tlb_q, res_pt_q, res_fault_q, res_cache_q;

  logic [SCAN_W-1:0]  scan_idx_q;
  logic [SCAN_W-1:0]  pick_q;
  logic [STAMP_W-1:0] least_q;

  logic out_valid_q;

  // TLB search, first match wins
  logic [TLB_ENTRIES-1:0] hit_vec;
  logic [TLB_IDX_W-1:0]   hit_idx;
  always_comb begin
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = tlb_valid_q[i] && (tlb_page_q[i] == page_q);
      if (hit_vec[i]) hit_idx = TLB_IDX_W'(i);
    end
  end

  // replacement scan, one entry per cycle
  logic               scan_valid;
  logic [STAMP_W-1:0] scan_stamp;
  logic [SCAN_W-1:0]  scan_last_idx;
  logic [SCAN_W-1:0]  pick_nxt;
  logic [STAMP_W-1:0] least_nxt;
  logic               found_nxt;
  always_comb begin
    if (cmd_i.scan_tlb) begin
      scan_valid    = tlb_valid_q[scan_idx_q[TLB_IDX_W-1:0]];
      scan_stamp    = tlb_stamp_q[scan_idx_q[TLB_IDX_W-1:0]];
      scan_last_idx = SCAN_W'(TLB_ENTRIES - 1);
    end else begin
      scan_valid    = frame_valid_q[scan_idx_q[FRAME_W-1:0]];
      scan_stamp    = frame_stamp_q[scan_idx_q[FRAME_W-1:0]];
      scan_last_idx = SCAN_W'(FRAMES - 1);
    end
    pick_nxt  = pick_q;
    least_nxt = least_q;
    found_nxt = 1'b0;
    if (!scan_valid) begin
      pick_nxt  = scan_idx_q;
      found_nxt = 1'b1;
    end else if (scan_stamp < least_q) begin
      pick_nxt  = scan_idx_q;
      least_nxt = scan_stamp;
    end
  end

  logic scan_last;
  assign scan_last = !scan_valid || (scan_idx_q == scan_last_idx);

  // cache lookup and victim choice
  logic [PA_W-1:0]  phys;
  logic [TAG_W-1:0] tag;
  logic [WAYS-1:0]  c_hit_vec;
  logic             c_hit;
  logic [1:0]       clear_cnt;
  logic [$clog2(WAYS)-1:0] c_pick;
  always_comb begin
    phys      = {frame_q, offset_q};
    tag       = phys[PA_W-1:PA_W-TAG_W];
    clear_cnt = '0;
    c_pick    = '0;
    for (int w = 0; w < WAYS; w++) begin
      c_hit_vec[w] = line_valid_q[w] && (line_tag_q[w] == tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!line_recent_q[w]) c_pick = ($clog2(WAYS))'(w);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!line_recent_q[w] && clear_cnt != 2'd2) clear_cnt = clear_cnt + 2'd1;
    end
  end
  assign c_hit = |c_hit_vec;

  assign status_o.tlb_hit     = |hit_vec;
  assign status_o.table_valid = table_valid_q[page_q];
  assign status_o.scan_last   = scan_last;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // control state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q   <= '0;
      table_valid_q <= '0;
      frame_valid_q <= '0;
      line_valid_q  <= '0;
      line_recent_q <= '0;
      res_tlb_q     <= 1'b0;
      res_pt_q      <= 1'b0;
      res_fault_q   <= 1'b0;
      res_cache_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.lookup) begin
        res_tlb_q   <= |hit_vec;
        res_pt_q    <= !(|hit_vec) && table_valid_q[page_q];
        res_fault_q <= !(|hit_vec) && !table_valid_q[page_q];
      end
      if (cmd_i.evict && !free_q) begin
        table_valid_q[frame_owner_q[frame_q]] <= 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (tlb_frame_q[i] == frame_q) tlb_valid_q[i] <= 1'b0;
        end
        for (int w = 0; w < WAYS; w++) begin
          if (line_tag_q[w][TAG_W-1:TAG_W-FRAME_W] == frame_q) begin
            line_valid_q[w]  <= 1'b0;
            line_recent_q[w] <= 1'b0;
          end
        end
      end
      if (cmd_i.map) begin
        table_valid_q[page_q] <= 1'b1;
        frame_valid_q[frame_q] <= 1'b1;
      end
      if (cmd_i.tlb_fill) tlb_valid_q[pick_q[TLB_IDX_W-1:0]] <= 1'b1;
      if (cmd_i.cache) begin
        res_cache_q <= c_hit;
        if (c_hit) begin
          for (int w = 0; w < WAYS; w++) begin
            if (c_hit_vec[w]) line_recent_q[w] <= 1'b1;
          end
        end else begin
          // with fewer than two clear bits, clear the set before marking the victim
          for (int w = 0; w < WAYS; w++) begin
            if (w == int'(c_pick)) line_recent_q[w] <= 1'b1;
            else if (clear_cnt != 2'd2) line_recent_q[w] <= 1'b0;
          end
          line_valid_q[c_pick] <= 1'b1;
        end
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    table_rdata_q <= table_mem[page_q];
    if (cmd_i.accept) begin
      page_q   <= virtual_address_i[OFF_W +: PAGE_W];
      offset_q <= virtual_address_i[OFF_W-1:0];
      stamp_q  <= cycle_stamp_i;
    end
    if (cmd_i.lookup && (|hit_vec)) begin
      frame_q              <= tlb_frame_q[hit_idx];
      tlb_stamp_q[hit_idx] <= stamp_q;
    end
    if (cmd_i.pt_load) frame_q <= table_rdata_q;
    if (cmd_i.scan_start) begin
      scan_idx_q <= '0;
      pick_q     <= '0;
      least_q    <= STAMP_CEIL;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + SCAN_W'(1);
      pick_q     <= pick_nxt;
      least_q    <= least_nxt;
      if (scan_last && !cmd_i.scan_tlb) begin
        frame_q <= pick_nxt[FRAME_W-1:0];
        free_q  <= found_nxt;
      end
    end
    if (cmd_i.map) begin
      table_mem[page_q]      <= frame_q;
      frame_owner_q[frame_q] <= page_q;
      frame_stamp_q[frame_q] <= stamp_q;
    end
    if (cmd_i.tlb_fill) begin
      tlb_page_q[pick_q[TLB_IDX_W-1:0]]  <= page_q;
      tlb_frame_q[pick_q[TLB_IDX_W-1:0]] <= frame_q;
      tlb_stamp_q[pick_q[TLB_IDX_W-1:0]] <= stamp_q;
    end
    if (cmd_i.cache && !c_hit) begin
      line_tag_q[c_pick]     <= tag;
      frame_stamp_q[frame_q] <= stamp_q;
    end
    if (cmd_i.load_out) begin
      tlb_hit_o          <= res_tlb_q;
      page_table_hit_o   <= res_pt_q;
      page_fault_o       <= res_fault_q;
      cache_hit_o        <= res_cache_q;
      frame_number_o     <= frame_q;
      physical_address_o <= phys;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== design/tlb_page_table_cache_access.sv =====
// Address translation and cache lookup for one memory side. Each input
// transfer carries a 10-bit virtual address and a 31-bit recency stamp and
// yields one result transfer: TLB hit, page-table hit or page fault, cache
// hit, the frame and the 6-bit physical address. Items are handled one at a
// time. A TLB hit goes through lookup, cache access and the load of the
// output register. A page-table hit adds the table memory read and a scan
// of the 32 TLB stamps for the refill slot, one entry a cycle and ending at
// the first invalid entry, plus the refill itself. A fault instead scans the
// 8 frame stamps one a cycle, ending at a free frame, then invalidates the
// page-table, TLB and cache entries of a victim that was in use, writes the
// new mapping, then scans and refills the TLB. The block returns to its idle
// state after each result before the next transfer is taken. The next
// transfer is taken once the result sits in the output register, even while
// that result is still stalled.
// Depends on tpca_pkg, tpca_ctrl, tpca_datapath and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tlb_page_table_cache_access (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tpca_pkg::VA_W-1:0]     virtual_address_i,
  input  wire logic [tpca_pkg::STAMP_W-1:0]  cycle_stamp_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               tlb_hit_o,
  output logic                               page_table_hit_o,
  output logic                               page_fault_o,
  output logic                               cache_hit_o,
  output logic [tpca_pkg::FRAME_W-1:0]       frame_number_o,
  output logic [tpca_pkg::PA_W-1:0]          physical_address_o
);
  import tpca_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequence each transfer through the datapath
  tpca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // hold all translation and cache state plus the output register
  tpca_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .virtual_address_i  (virtual_address_i),
    .cycle_stamp_i      (cycle_stamp_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .tlb_hit_o          (tlb_hit_o),
    .page_table_hit_o   (page_table_hit_o),
    .page_fault_o       (page_fault_o),
    .cache_hit_o        (cache_hit_o),
    .frame_number_o     (frame_number_o),
    .physical_address_o (physical_address_o)
  );

  // exactly one translation outcome per result
  `ASSERT_IMPLY(a_one_outcome, clk_i, rst_ni, out_valid_o, $onehot({tlb_hit_o, page_table_hit_o, page_fault_o}))
  // physical address carries the frame in its upper bits
  `ASSERT_IMPLY(a_frame_in_pa, clk_i, rst_ni, out_valid_o, physical_address_o[PA_W-1:OFF_W] == frame_number_o)
  // an accepted transfer makes the block busy in the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule
`default_nettype wire
